>>> rtl/psc_pkg.sv
// Shared types and constants for the parabolic sine/cosine pipeline.
// Used by psc_front, psc_lane and parabolic_sine_cosine; no dependencies.
package psc_pkg;

    localparam int ANGLE_W     = 16;
    localparam int OUT_W       = 16;
    localparam int MAG_W       = 15;
    localparam int WRAP_W      = 18;
    localparam int ANGLE_FRAC  = 13;
    localparam int OUT_FRAC    = 14;
    localparam int INT_FRAC    = 30;
    localparam int LANE_STAGES = 6;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    // Angle constants in Q3.13
    localparam logic signed [WRAP_W-1:0] PI_Q      = 18'sd25736;
    localparam logic signed [WRAP_W-1:0] HALF_PI_Q = 18'sd12868;
    localparam logic signed [WRAP_W-1:0] TWO_PI_Q  = 18'sd51472;

    // Parabola coefficients in Q30
    localparam logic [30:0] COEF_B  = 31'd1367130551;
    localparam logic [28:0] COEF_C  = 29'd435171170;
    localparam logic [27:0] COEF_K  = 28'd241591910;
    localparam logic [32:0] ONE_Q30 = 33'd1073741824;

    localparam int OUT_SHIFT = INT_FRAC - OUT_FRAC;

    typedef struct packed {
        logic             neg_s;
        logic [MAG_W-1:0] mag_s;
        logic             neg_c;
        logic [MAG_W-1:0] mag_c;
    } t_front;

endpackage

>>> rtl/parabolic_sine_cosine.sv
// Parabolic sine/cosine approximation, top level.
// Depends on psc_pkg, psc_front and psc_lane.
//
// Usage:
//   Slave channel (i_s_*) takes one angle per item, signed Q3.13 radians.
//   Angles outside [-pi, pi] are clamped. Master channel (o_m_*) gives one
//   item per angle: sine in bits 15:0 and cosine in bits 31:16, Q1.14.
//   i_cfg_wen/i_cfg_wdata write refine_enable: 1 adds the 0.225 refinement
//   and clamps to [-1, 1], 0 gives the plain parabola. Write only while idle.
// Pipeline: one clamp/wrap stage, six lane stages; the last is the output
//   register. Throughput: one item per cycle while i_m_tready is high;
//   the stage count follows the two chained multiplies of the parabola
//   and the two of the refinement.
// Reset: synchronous, active low; empties the pipeline, sets refine_enable.
// Stall: if i_m_tready is low, full stages behind an empty one move on;
//   so o_s_tready falls only once all seven stages hold an item.
module parabolic_sine_cosine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic        i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] angle
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [15:0] sine, [31:16] cosine
);

    localparam int N = psc_pkg::PIPE_STAGES;

    logic                r_refine;
    logic [N-1:0]        r_valid;
    logic [N-1:0]        n_valid;
    logic [N:0]          w_rdy;
    logic [N-1:0]        w_en;
    psc_pkg::t_front     w_front;
    logic signed [15:0]  w_sine;
    logic signed [15:0]  w_cosine;

    always_comb begin
        w_rdy[N] = i_m_tready;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_valid[k] || w_rdy[k+1];
        end
        w_en = w_rdy[N-1:0];
        n_valid[0] = w_en[0] ? i_s_tvalid : r_valid[0];
        for (int k = 1; k < N; k++) begin
            n_valid[k] = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_refine <= 1'b1;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_wen) begin
                r_refine <= i_cfg_wdata;
            end
        end
    end

    psc_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_angle (i_s_tdata),
        .o_front (w_front)
    );

    psc_lane u_lane_sin (
        .i_clk    (i_clk),
        .i_en     (w_en[N-1:1]),
        .i_refine (r_refine),
        .i_neg    (w_front.neg_s),
        .i_mag    (w_front.mag_s),
        .o_value  (w_sine)
    );

    psc_lane u_lane_cos (
        .i_clk    (i_clk),
        .i_en     (w_en[N-1:1]),
        .i_refine (r_refine),
        .i_neg    (w_front.neg_c),
        .i_mag    (w_front.mag_c),
        .o_value  (w_cosine)
    );

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_valid[N-1];
    assign o_m_tdata  = {w_cosine, w_sine};

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_valid))
        else $error("input blocked while a stage is empty");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid == '0) |-> o_s_tready)
        else $error("empty pipeline not ready");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ($countones(r_valid) <= $countones($past(r_valid)) + 1))
        else $error("more than one item entered in a cycle");

    a_refined_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_refine) |->
            (w_sine <= 16'sd16384 && w_sine >= -16'sd16384 &&
             w_cosine <= 16'sd16384 && w_cosine >= -16'sd16384))
        else $error("refined result outside [-1, 1]");

endmodule

>>> rtl/psc_front.sv
// Input stage: clamp the angle to [-pi, pi], form the cosine angle and
// split both into sign and magnitude. Depends on psc_pkg.
module psc_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [psc_pkg::ANGLE_W-1:0]  i_angle,
    output psc_pkg::t_front                     o_front
);

    logic signed [psc_pkg::WRAP_W-1:0] w_x;
    logic signed [psc_pkg::WRAP_W-1:0] w_xc;
    logic signed [psc_pkg::WRAP_W-1:0] w_xs;
    logic signed [psc_pkg::WRAP_W-1:0] w_abs_s;
    logic signed [psc_pkg::WRAP_W-1:0] w_abs_c;
    psc_pkg::t_front                   r_front;
    psc_pkg::t_front                   n_front;

    always_comb begin
        w_x = psc_pkg::WRAP_W'(i_angle);
        if (w_x > psc_pkg::PI_Q) begin
            w_x = psc_pkg::PI_Q;
        end
        if (w_x < -psc_pkg::PI_Q) begin
            w_x = -psc_pkg::PI_Q;
        end
        w_xs = w_x + psc_pkg::HALF_PI_Q;
        w_xc = (w_xs > psc_pkg::PI_Q) ? (w_xs - psc_pkg::TWO_PI_Q) : w_xs;
        w_abs_s = w_x[psc_pkg::WRAP_W-1] ? -w_x : w_x;
        w_abs_c = w_xc[psc_pkg::WRAP_W-1] ? -w_xc : w_xc;
        n_front.neg_s = w_x[psc_pkg::WRAP_W-1];
        n_front.mag_s = w_abs_s[psc_pkg::MAG_W-1:0];
        n_front.neg_c = w_xc[psc_pkg::WRAP_W-1];
        n_front.mag_c = w_abs_c[psc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

>>> rtl/psc_lane.sv
// One parabola lane: products, difference, optional refinement, rounding
// and sign, over six register stages. Depends on psc_pkg.
module psc_lane (
    input  logic                                    i_clk,
    input  logic [psc_pkg::LANE_STAGES-1:0]         i_en,
    input  logic                                    i_refine,
    input  logic                                    i_neg,
    input  logic [psc_pkg::MAG_W-1:0]               i_mag,
    output logic signed [psc_pkg::OUT_W-1:0]        o_value
);

    logic [45:0] w_pb;
    logic [29:0] w_pa;
    logic [45:0] w_pc;
    logic [61:0] w_pm;
    logic [30:0] w_d;
    logic [58:0] w_pk;
    logic [32:0] w_diff;
    logic [32:0] w_mf;
    logic [33:0] w_rs;
    logic [17:0] w_r;
    logic [17:0] w_sr;

    logic [psc_pkg::LANE_STAGES-2:0] r_neg;
    logic [32:0] r_t1_a;
    logic [16:0] r_sq;
    logic [32:0] r_t1_b;
    logic [32:0] r_t2;
    logic [32:0] r_m_c;
    logic [32:0] r_m_d;
    logic [30:0] r_m2;
    logic [32:0] r_m_e;
    logic [28:0] r_kd;
    logic signed [psc_pkg::OUT_W-1:0] r_out;

    always_comb begin
        w_pb   = 46'(psc_pkg::COEF_B) * 46'(i_mag);
        w_pa   = 30'(i_mag) * 30'(i_mag);
        w_pc   = 46'(psc_pkg::COEF_C) * 46'(r_sq);
        w_diff = (r_t1_b > r_t2) ? (r_t1_b - r_t2) : 33'd0;
        w_pm   = 62'(r_m_c[30:0]) * 62'(r_m_c[30:0]);
        w_d    = r_m_d[30:0] - r_m2;
        w_pk   = 59'(psc_pkg::COEF_K) * 59'(w_d);
        w_mf   = i_refine ? (r_m_e - 33'(r_kd)) : r_m_e;
        w_rs   = 34'(w_mf) + (34'd1 << (psc_pkg::OUT_SHIFT - 1));
        w_r    = w_rs[psc_pkg::OUT_SHIFT +: 18];
        w_sr   = r_neg[psc_pkg::LANE_STAGES-2] ? -w_r : w_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg[0] <= i_neg;
            r_t1_a   <= 33'((w_pb + 46'd4096) >> psc_pkg::ANGLE_FRAC);
            r_sq     <= 17'((w_pa + 30'd4096) >> psc_pkg::ANGLE_FRAC);
        end
        if (i_en[1]) begin
            r_neg[1] <= r_neg[0];
            r_t1_b   <= r_t1_a;
            r_t2     <= 33'((w_pc + 46'd4096) >> psc_pkg::ANGLE_FRAC);
        end
        if (i_en[2]) begin
            r_neg[2] <= r_neg[1];
            r_m_c    <= (i_refine && w_diff > psc_pkg::ONE_Q30) ? psc_pkg::ONE_Q30 : w_diff;
        end
        if (i_en[3]) begin
            r_neg[3] <= r_neg[2];
            r_m_d    <= r_m_c;
            r_m2     <= 31'((w_pm + (62'd1 << 29)) >> psc_pkg::INT_FRAC);
        end
        if (i_en[4]) begin
            r_neg[4] <= r_neg[3];
            r_m_e    <= r_m_d;
            r_kd     <= 29'((w_pk + (59'd1 << 29)) >> psc_pkg::INT_FRAC);
        end
        if (i_en[5]) begin
            r_out    <= w_sr[psc_pkg::OUT_W-1:0];
        end
    end

    assign o_value = r_out;

endmodule
